FILE: sv/assert_macros.svh
// assertion macros shared by the sphere overlap rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SOV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");
`define SOV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");
`else
`define SOV_ASSERT_IMP(lbl, ante, cons)
`define SOV_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/sov_pkg.sv
// shared widths, constants and types for the sphere overlap pipeline
// no dependencies
package sov_pkg;

  localparam int IN_W      = 32;
  localparam int FRAC_BITS = 16;
  localparam int OUT_W     = 64;

  localparam int SUM_W  = IN_W + 1;
  localparam int PROD_W = 2 * SUM_W;
  localparam int DEN_W  = IN_W + 1;
  localparam int QUO_W  = IN_W + 2;
  localparam int H_W    = IN_W + 1;
  localparam int M_W    = IN_W + 2;

  // wide multiplier geometry
  localparam int LIMB_W  = 32;
  localparam int MA_W    = 4 * LIMB_W;
  localparam int MB_W    = 2 * LIMB_W;
  localparam int MP_W    = MA_W + MB_W;
  localparam int MUL_LAT = 3;

  localparam logic [MB_W-1:0] PI60 = 64'h3243F6A8885A308D;

  localparam int VOL_SHIFT  = 2 * FRAC_BITS + 60;
  localparam int SURF_SHIFT = FRAC_BITS + 59;

  // divide by three, one 16-bit digit per stage
  localparam int DIG_W     = 16;
  localparam int X_W       = DIG_W + 2;
  localparam int D3_IN_W   = OUT_W + 2;
  localparam int D3_LAT    = (D3_IN_W + DIG_W - 1) / DIG_W;
  localparam int D3_W      = D3_LAT * DIG_W;
  localparam int D3_SHIFT  = DIG_W + 3;
  localparam logic [X_W-1:0] D3_RECIP = X_W'(((1 << D3_SHIFT) + 2) / 3);

  typedef enum logic [1:0] {
    CASE_NONE    = 2'd0,
    CASE_PARTIAL = 2'd1,
    CASE_ONE_IN  = 2'd2,
    CASE_TWO_IN  = 2'd3
  } contact_t;

  typedef struct packed {
    contact_t          kind;
    logic [IN_W-1:0]   r1;
    logic [IN_W-1:0]   r2;
  } side_t;

  typedef struct packed {
    contact_t          contact_case;
    logic [OUT_W-1:0]  overlap_surface_two;
    logic [OUT_W-1:0]  overlap_surface_one;
    logic [OUT_W-1:0]  overlap_volume_two;
    logic [OUT_W-1:0]  overlap_volume_one;
  } res_t;

endpackage

FILE: sv/sphere_overlap_cap_volume.sv
// top level of the sphere overlap cap volume and surface pipeline
// depends on sov_pkg, sov_mul, sov_div, sov_div3 and assert_macros.svh
//
// Takes one sphere pair per cycle while in_tready is high (radii and centre
// distance, unsigned Q16.16) and returns, for each sphere, the volume and
// surface of its part inside the other sphere as saturating Q48.16, plus a
// contact code. A new item is taken every cycle while in_tready is high. The
// depth is set mainly by the 34-stage bit-per-stage divider that forms the cap
// heights, fed by a 128 x 64 multiplier pipeline for its numerators, then three
// chained 128 x 64 multiplier pipelines (h*h, times 3r-h, times pi) and a
// five-digit divide by three, plus the input, classify and height registers.
// The whole pipeline moves on one enable; a two-entry output buffer lets the
// block keep taking items while a finished result waits, and in_tready drops
// only once that buffer is full.
`include "assert_macros.svh"

module sphere_overlap_cap_volume (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: radius_one [31:0], radius_two [63:32], center_distance [95:64]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,
  // out_tdata: overlap_volume_one [63:0], overlap_volume_two [127:64],
  //   overlap_surface_one [191:128], overlap_surface_two [255:192],
  //   contact_case [257:256], zero fill [263:258]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [263:0] out_tdata
);

  localparam int IN_W    = sov_pkg::IN_W;
  localparam int OUT_W   = sov_pkg::OUT_W;
  localparam int SUM_W   = sov_pkg::SUM_W;
  localparam int DEN_W   = sov_pkg::DEN_W;
  localparam int QUO_W   = sov_pkg::QUO_W;
  localparam int PROD_W  = sov_pkg::PROD_W;
  localparam int H_W     = sov_pkg::H_W;
  localparam int M_W     = sov_pkg::M_W;
  localparam int MA_W    = sov_pkg::MA_W;
  localparam int MB_W    = sov_pkg::MB_W;
  localparam int MP_W    = sov_pkg::MP_W;
  localparam int MUL_LAT = sov_pkg::MUL_LAT;
  localparam int DIV_LAT = sov_pkg::QUO_W;
  localparam int D3_LAT  = sov_pkg::D3_LAT;
  localparam int D3_IN_W = sov_pkg::D3_IN_W;
  localparam int OUT_TDATA_W = 264;

  // stage bookkeeping: input, classify, a*b, divider, height, three multiplies, /3
  localparam int NSTG     = 3 + MUL_LAT + DIV_LAT + 3 * MUL_LAT + D3_LAT;
  localparam int SIDE_DLY = MUL_LAT + DIV_LAT;
  localparam int KIND_DLY = 3 * MUL_LAT + D3_LAT;
  localparam int SURF_DLY = MUL_LAT + D3_LAT;

  // flow control
  logic                    en;
  logic                    push;
  logic                    pop;
  logic [NSTG-1:0]         vld_r;
  sov_pkg::res_t           out_r;
  sov_pkg::res_t           skid_r;
  logic                    out_vld_r;
  logic                    full_r;

  // input stage
  logic [IN_W-1:0]         rad1_r, rad2_r, dist_r;

  // classify stage
  logic [SUM_W-1:0]        sum_c, a1_c, a2_c, b_c;
  logic [IN_W-1:0]         diff_c;
  logic                    touch_c, apart_c;
  sov_pkg::contact_t       kind_c;
  sov_pkg::side_t          cls_side_r;
  logic [SUM_W-1:0]        a1_r, a2_r, b_r;
  logic [DEN_W-1:0]        den_r;

  // cap height products and division
  logic [MP_W-1:0]         ab1_p, ab2_p;
  logic [DEN_W-1:0]        den_d_r  [MUL_LAT];
  sov_pkg::side_t          side_d_r [SIDE_DLY];
  logic [QUO_W-1:0]        q1, q2;
  sov_pkg::side_t          sd;

  // height stage
  logic [H_W-1:0]          h1_c, h2_c, h1_r, h2_r;
  logic [M_W-1:0]          m1_c, m2_c, m1_r, m2_r;
  logic [IN_W-1:0]         rr1_r, rr2_r;
  sov_pkg::contact_t       kind_h_r;

  // multiplier chain
  logic [MP_W-1:0]         hh1_p, hh2_p, rh1_p, rh2_p;
  logic [MP_W-1:0]         u1_p, u2_p, sp1_p, sp2_p, v1_p, v2_p;
  logic [M_W-1:0]          m1_d_r [MUL_LAT];
  logic [M_W-1:0]          m2_d_r [MUL_LAT];
  logic [OUT_W-1:0]        surf1_c, surf2_c;
  logic [OUT_W-1:0]        surf1_d_r [SURF_DLY];
  logic [OUT_W-1:0]        surf2_d_r [SURF_DLY];
  logic                    sat1_c, sat2_c;
  logic                    sat1_d_r [D3_LAT];
  logic                    sat2_d_r [D3_LAT];
  sov_pkg::contact_t       kind_d_r [KIND_DLY];
  logic [OUT_W-1:0]        vq1, vq2;
  sov_pkg::res_t           res_c;

  assign en        = !full_r;
  assign in_tready = en;
  assign push      = en && vld_r[NSTG-1];
  assign pop       = out_vld_r && out_tready;

  // classify the pair and form the cap height numerators
  always_comb begin
    sum_c   = SUM_W'(rad1_r) + SUM_W'(rad2_r);
    diff_c  = (rad1_r > rad2_r) ? rad1_r - rad2_r : rad2_r - rad1_r;
    touch_c = (dist_r != '0) && (SUM_W'(dist_r) < sum_c);
    apart_c = dist_r >= diff_c;
    priority if (!touch_c) begin
      kind_c = sov_pkg::CASE_NONE;
    end else if (apart_c) begin
      kind_c = sov_pkg::CASE_PARTIAL;
    end else if (rad1_r < rad2_r) begin
      kind_c = sov_pkg::CASE_ONE_IN;
    end else begin
      kind_c = sov_pkg::CASE_TWO_IN;
    end
    // only partial overlap divides; other cases feed zeros
    if (kind_c == sov_pkg::CASE_PARTIAL) begin
      a1_c = SUM_W'(rad2_r) + SUM_W'(dist_r) - SUM_W'(rad1_r);
      a2_c = SUM_W'(rad1_r) + SUM_W'(dist_r) - SUM_W'(rad2_r);
      b_c  = sum_c - SUM_W'(dist_r);
    end else begin
      a1_c = '0;
      a2_c = '0;
      b_c  = '0;
    end
  end

  // (r2+d-r1)(r1+r2-d) and (r1+d-r2)(r1+r2-d)
  sov_mul u_mul_ab1 (.clk, .en, .a(MA_W'(a1_r)), .b(MB_W'(b_r)), .p(ab1_p));
  sov_mul u_mul_ab2 (.clk, .en, .a(MA_W'(a2_r)), .b(MB_W'(b_r)), .p(ab2_p));

  // cap heights, floor of product over 2d
  sov_div u_div1 (.clk, .en, .num(ab1_p[PROD_W-1:0]), .den(den_d_r[MUL_LAT-1]), .quo(q1));
  sov_div u_div2 (.clk, .en, .num(ab2_p[PROD_W-1:0]), .den(den_d_r[MUL_LAT-1]), .quo(q2));

  // pick the height per case; containment uses h = 2r, the other sphere h = 0
  always_comb begin
    sd = side_d_r[SIDE_DLY-1];
    unique case (sd.kind)
      sov_pkg::CASE_PARTIAL: begin
        h1_c = q1[H_W-1:0];
        h2_c = q2[H_W-1:0];
      end
      sov_pkg::CASE_ONE_IN: begin
        h1_c = {sd.r1, 1'b0};
        h2_c = '0;
      end
      sov_pkg::CASE_TWO_IN: begin
        h1_c = '0;
        h2_c = {sd.r2, 1'b0};
      end
      sov_pkg::CASE_NONE: begin
        h1_c = '0;
        h2_c = '0;
      end
    endcase
    m1_c = M_W'({sd.r1, 1'b0}) + M_W'(sd.r1) - M_W'(h1_c);
    m2_c = M_W'({sd.r2, 1'b0}) + M_W'(sd.r2) - M_W'(h2_c);
  end

  // h*h and r*h
  sov_mul u_mul_hh1 (.clk, .en, .a(MA_W'(h1_r)), .b(MB_W'(h1_r)), .p(hh1_p));
  sov_mul u_mul_hh2 (.clk, .en, .a(MA_W'(h2_r)), .b(MB_W'(h2_r)), .p(hh2_p));
  sov_mul u_mul_rh1 (.clk, .en, .a(MA_W'(rr1_r)), .b(MB_W'(h1_r)), .p(rh1_p));
  sov_mul u_mul_rh2 (.clk, .en, .a(MA_W'(rr2_r)), .b(MB_W'(h2_r)), .p(rh2_p));

  // h*h*(3r-h) and r*h*pi
  sov_mul u_mul_u1 (.clk, .en, .a(hh1_p[MA_W-1:0]), .b(MB_W'(m1_d_r[MUL_LAT-1])), .p(u1_p));
  sov_mul u_mul_u2 (.clk, .en, .a(hh2_p[MA_W-1:0]), .b(MB_W'(m2_d_r[MUL_LAT-1])), .p(u2_p));
  sov_mul u_mul_s1 (.clk, .en, .a(rh1_p[MA_W-1:0]), .b(sov_pkg::PI60), .p(sp1_p));
  sov_mul u_mul_s2 (.clk, .en, .a(rh2_p[MA_W-1:0]), .b(sov_pkg::PI60), .p(sp2_p));

  // h*h*(3r-h)*pi
  sov_mul u_mul_v1 (.clk, .en, .a(u1_p[MA_W-1:0]), .b(sov_pkg::PI60), .p(v1_p));
  sov_mul u_mul_v2 (.clk, .en, .a(u2_p[MA_W-1:0]), .b(sov_pkg::PI60), .p(v2_p));

  // surface scaling and saturation
  always_comb begin
    surf1_c = (|sp1_p[MP_W-1:sov_pkg::SURF_SHIFT+OUT_W]) ? '1
            : sp1_p[sov_pkg::SURF_SHIFT +: OUT_W];
    surf2_c = (|sp2_p[MP_W-1:sov_pkg::SURF_SHIFT+OUT_W]) ? '1
            : sp2_p[sov_pkg::SURF_SHIFT +: OUT_W];
    // quotient by three overflows once the shifted product reaches 3 * 2^64
    sat1_c  = v1_p[MP_W-1:sov_pkg::VOL_SHIFT+OUT_W] >= 3;
    sat2_c  = v2_p[MP_W-1:sov_pkg::VOL_SHIFT+OUT_W] >= 3;
  end

  sov_div3 u_div3_1 (.clk, .en, .num(v1_p[sov_pkg::VOL_SHIFT +: D3_IN_W]), .quo(vq1));
  sov_div3 u_div3_2 (.clk, .en, .num(v2_p[sov_pkg::VOL_SHIFT +: D3_IN_W]), .quo(vq2));

  // assemble the finished item
  always_comb begin
    res_c.contact_case        = kind_d_r[KIND_DLY-1];
    res_c.overlap_volume_one  = sat1_d_r[D3_LAT-1] ? '1 : vq1;
    res_c.overlap_volume_two  = sat2_d_r[D3_LAT-1] ? '1 : vq2;
    res_c.overlap_surface_one = surf1_d_r[SURF_DLY-1];
    res_c.overlap_surface_two = surf2_d_r[SURF_DLY-1];
  end

  // payload registers and delay lines, all on the common enable
  always_ff @(posedge clk) begin
    if (en) begin
      rad1_r <= in_tdata[IN_W-1:0];
      rad2_r <= in_tdata[2*IN_W-1:IN_W];
      dist_r <= in_tdata[3*IN_W-1:2*IN_W];

      cls_side_r.kind <= kind_c;
      cls_side_r.r1   <= rad1_r;
      cls_side_r.r2   <= rad2_r;
      a1_r  <= a1_c;
      a2_r  <= a2_c;
      b_r   <= b_c;
      den_r <= {dist_r, 1'b0};

      den_d_r[0] <= den_r;
      for (int i = 1; i < MUL_LAT; i++) den_d_r[i] <= den_d_r[i-1];
      side_d_r[0] <= cls_side_r;
      for (int i = 1; i < SIDE_DLY; i++) side_d_r[i] <= side_d_r[i-1];

      h1_r     <= h1_c;
      h2_r     <= h2_c;
      m1_r     <= m1_c;
      m2_r     <= m2_c;
      rr1_r    <= sd.r1;
      rr2_r    <= sd.r2;
      kind_h_r <= sd.kind;

      m1_d_r[0] <= m1_r;
      m2_d_r[0] <= m2_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        m1_d_r[i] <= m1_d_r[i-1];
        m2_d_r[i] <= m2_d_r[i-1];
      end
      kind_d_r[0] <= kind_h_r;
      for (int i = 1; i < KIND_DLY; i++) kind_d_r[i] <= kind_d_r[i-1];
      surf1_d_r[0] <= surf1_c;
      surf2_d_r[0] <= surf2_c;
      for (int i = 1; i < SURF_DLY; i++) begin
        surf1_d_r[i] <= surf1_d_r[i-1];
        surf2_d_r[i] <= surf2_d_r[i-1];
      end
      sat1_d_r[0] <= sat1_c;
      sat2_d_r[0] <= sat2_c;
      for (int i = 1; i < D3_LAT; i++) begin
        sat1_d_r[i] <= sat1_d_r[i-1];
        sat2_d_r[i] <= sat2_d_r[i-1];
      end
    end
  end

  // valid bits travel alongside the payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // two-entry output buffer: head register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      full_r    <= 1'b0;
    end else if (full_r) begin
      if (pop) begin
        full_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_vld_r <= 1'b1;
      end else begin
        full_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (full_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_r <= res_c;
      end else begin
        skid_r <= res_c;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'(out_r);

  // a held skid entry always sits behind a valid head
  `SOV_ASSERT_IMP(a_skid_behind_head, full_r, out_vld_r)
  // the skid entry is never dropped while the sink stalls
  `SOV_ASSERT_NXT(a_skid_kept, full_r && !out_tready, full_r)
  // no contact reports nothing
  `SOV_ASSERT_IMP(a_none_zero,
    out_vld_r && out_r.contact_case == sov_pkg::CASE_NONE,
    out_r.overlap_volume_one == '0 && out_r.overlap_volume_two == '0 &&
    out_r.overlap_surface_one == '0 && out_r.overlap_surface_two == '0)
  // the outer sphere of a contained pair reports nothing
  `SOV_ASSERT_IMP(a_outer_zero,
    out_vld_r && (out_r.contact_case == sov_pkg::CASE_ONE_IN ||
                  out_r.contact_case == sov_pkg::CASE_TWO_IN),
    (out_r.contact_case == sov_pkg::CASE_ONE_IN) ?
      (out_r.overlap_volume_two == '0 && out_r.overlap_surface_two == '0) :
      (out_r.overlap_volume_one == '0 && out_r.overlap_surface_one == '0))

endmodule

FILE: sv/sov_mul.sv
// pipelined 128 x 64 unsigned multiplier built from 32 x 32 partial products
// depends on sov_pkg
module sov_mul (
  input  logic                      clk,
  input  logic                      en,
  input  logic [sov_pkg::MA_W-1:0]  a,
  input  logic [sov_pkg::MB_W-1:0]  b,
  output logic [sov_pkg::MP_W-1:0]  p
);

  localparam int LW  = sov_pkg::LIMB_W;
  localparam int AL  = sov_pkg::MA_W / LW;
  localparam int BL  = sov_pkg::MB_W / LW;
  localparam int RW  = sov_pkg::MA_W + LW;

  logic [2*LW-1:0]           pp_r  [AL][BL];
  logic [RW-1:0]             row_r [BL];
  logic [sov_pkg::MP_W-1:0]  p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AL; i++) begin
        for (int j = 0; j < BL; j++) begin
          pp_r[i][j] <= a[LW*i +: LW] * b[LW*j +: LW];
        end
      end
      // even limbs do not overlap, nor do odd ones: one add per row
      for (int j = 0; j < BL; j++) begin
        row_r[j] <= {{LW{1'b0}}, pp_r[2][j], pp_r[0][j]}
                  + {pp_r[3][j], pp_r[1][j], {LW{1'b0}}};
      end
      p_r <= {{LW{1'b0}}, row_r[0]} + {row_r[1], {LW{1'b0}}};
    end
  end

  assign p = p_r;

endmodule

FILE: sv/sov_div.sv
// pipelined restoring divider for the cap height, one quotient bit per stage
// depends on sov_pkg; quotient must fit in QUO_W bits
module sov_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [sov_pkg::PROD_W-1:0]  num,
  input  logic [sov_pkg::DEN_W-1:0]   den,
  output logic [sov_pkg::QUO_W-1:0]   quo
);

  localparam int NW = sov_pkg::PROD_W;
  localparam int DW = sov_pkg::DEN_W;
  localparam int QW = sov_pkg::QUO_W;
  localparam int NS = QW;

  logic [DW-1:0] rem_r  [NS];
  logic [DW-1:0] den_r  [NS];
  logic [QW-1:0] low_r  [NS];
  logic [QW-1:0] quo_r  [NS];

  logic [DW-1:0] rem_in  [NS];
  logic [DW-1:0] den_in  [NS];
  logic [QW-1:0] low_in  [NS];
  logic [QW-1:0] quo_in  [NS];
  logic [DW:0]   trial   [NS];
  logic          fits    [NS];
  logic [DW-1:0] rem_nxt [NS];
  logic [QW-1:0] low_nxt [NS];
  logic [QW-1:0] quo_nxt [NS];

  always_comb begin
    rem_in[0] = DW'(num[NW-1:QW]);
    den_in[0] = den;
    low_in[0] = num[QW-1:0];
    quo_in[0] = '0;
    for (int s = 1; s < NS; s++) begin
      rem_in[s] = rem_r[s-1];
      den_in[s] = den_r[s-1];
      low_in[s] = low_r[s-1];
      quo_in[s] = quo_r[s-1];
    end
    for (int s = 0; s < NS; s++) begin
      trial[s]   = {rem_in[s], low_in[s][QW-1]};
      fits[s]    = trial[s] >= {1'b0, den_in[s]};
      rem_nxt[s] = fits[s] ? DW'(trial[s] - {1'b0, den_in[s]}) : trial[s][DW-1:0];
      low_nxt[s] = {low_in[s][QW-2:0], 1'b0};
      quo_nxt[s] = {quo_in[s][QW-2:0], fits[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= den_in[s];
        low_r[s] <= low_nxt[s];
        quo_r[s] <= quo_nxt[s];
      end
    end
  end

  assign quo = quo_r[NS-1];

endmodule

FILE: sv/sov_div3.sv
// pipelined divide by three, one 16-bit digit per stage via reciprocal multiply
// depends on sov_pkg; input must be below 3 * 2^64
module sov_div3 (
  input  logic                         clk,
  input  logic                         en,
  input  logic [sov_pkg::D3_IN_W-1:0]  num,
  output logic [sov_pkg::OUT_W-1:0]    quo
);

  localparam int NS = sov_pkg::D3_LAT;
  localparam int W  = sov_pkg::D3_W;
  localparam int DG = sov_pkg::DIG_W;
  localparam int XW = sov_pkg::X_W;

  logic [W-1:0]    num_r [NS];
  logic [W-1:0]    quo_r [NS];
  logic [1:0]      rem_r [NS];

  logic [W-1:0]    num_in  [NS];
  logic [W-1:0]    quo_in  [NS];
  logic [1:0]      rem_in  [NS];
  logic [XW-1:0]   x       [NS];
  logic [2*XW-1:0] prod    [NS];
  logic [DG-1:0]   qd      [NS];
  logic [1:0]      rem_nxt [NS];

  always_comb begin
    num_in[0] = W'(num);
    quo_in[0] = '0;
    rem_in[0] = '0;
    for (int s = 1; s < NS; s++) begin
      num_in[s] = num_r[s-1];
      quo_in[s] = quo_r[s-1];
      rem_in[s] = rem_r[s-1];
    end
    for (int s = 0; s < NS; s++) begin
      x[s]       = {rem_in[s], num_in[s][W-1 -: DG]};
      prod[s]    = x[s] * sov_pkg::D3_RECIP;
      qd[s]      = prod[s][sov_pkg::D3_SHIFT +: DG];
      rem_nxt[s] = 2'(x[s] - XW'(qd[s]) * XW'(3));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        num_r[s] <= {num_in[s][W-DG-1:0], {DG{1'b0}}};
        quo_r[s] <= {quo_in[s][W-DG-1:0], qd[s]};
        rem_r[s] <= rem_nxt[s];
      end
    end
  end

  assign quo = quo_r[NS-1][sov_pkg::OUT_W-1:0];

endmodule

FILE: bench/testbench.sv
// self-checking bench for sphere_overlap_cap_volume: directed and random sphere pairs
// depends on sov_pkg and the dut rtl; exact wide-integer prediction inside a scoreboard class
`timescale 1ns / 1ps

module testbench;

  localparam int  RANDOM_PAIRS = 1880;
  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  DRAIN_CYCLES = 80;
  localparam logic [255:0] PI_Q60 = 256'h3243F6A8885A308D;
  localparam logic [255:0] SAT64  = 256'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [63:0]        vol_one;
    logic [63:0]        vol_two;
    logic [63:0]        surf_one;
    logic [63:0]        surf_two;
    sov_pkg::contact_t  kind;
  } overlap_t;

  // holds predicted overlaps in order and checks each delivered one
  class overlap_scoreboard;
    overlap_t expected_q[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function logic [63:0] clip(logic [255:0] v);
      return (v > SAT64) ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
    endfunction

    // cap volume pi*h^2*(3r-h)/3 and surface 2*pi*r*h, floored
    static function void cap_of(logic [255:0] r, logic [255:0] h,
                                output logic [63:0] vol, output logic [63:0] surf);
      logic [255:0] acc;
      acc  = h * h * (3 * r - h) * PI_Q60;
      acc  = (acc / 3) >> sov_pkg::VOL_SHIFT;
      vol  = clip(acc);
      acc  = (r * h * PI_Q60) >> sov_pkg::SURF_SHIFT;
      surf = clip(acc);
    endfunction

    function void note_pair(logic [31:0] r1_in, logic [31:0] r2_in, logic [31:0] d_in);
      logic [255:0] r1, r2, d, sum, gap, h1, h2;
      overlap_t     o;
      r1 = r1_in; r2 = r2_in; d = d_in;
      sum = r1 + r2;
      gap = (r1 > r2) ? r1 - r2 : r2 - r1;
      o = '{64'd0, 64'd0, 64'd0, 64'd0, sov_pkg::CASE_NONE};
      if (d != 0 && d < sum) begin
        if (d >= gap) begin
          h1 = ((r2 + d - r1) * (sum - d)) / (2 * d);
          h2 = ((r1 + d - r2) * (sum - d)) / (2 * d);
          cap_of(r1, h1, o.vol_one, o.surf_one);
          cap_of(r2, h2, o.vol_two, o.surf_two);
          o.kind = sov_pkg::CASE_PARTIAL;
        end else if (r1 < r2) begin
          cap_of(r1, 2 * r1, o.vol_one, o.surf_one);
          o.kind = sov_pkg::CASE_ONE_IN;
        end else begin
          cap_of(r2, 2 * r2, o.vol_two, o.surf_two);
          o.kind = sov_pkg::CASE_TWO_IN;
        end
      end
      expected_q.push_back(o);
    endfunction

    function void check_result(logic [263:0] data);
      overlap_t o;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        mismatches++;
        return;
      end
      o = expected_q.pop_front();
      if (data[63:0] !== o.vol_one) begin
        $display("%0t: volume one exp %h got %h", $time, o.vol_one, data[63:0]);
        mismatches++;
      end
      if (data[127:64] !== o.vol_two) begin
        $display("%0t: volume two exp %h got %h", $time, o.vol_two, data[127:64]);
        mismatches++;
      end
      if (data[191:128] !== o.surf_one) begin
        $display("%0t: surface one exp %h got %h", $time, o.surf_one, data[191:128]);
        mismatches++;
      end
      if (data[255:192] !== o.surf_two) begin
        $display("%0t: surface two exp %h got %h", $time, o.surf_two, data[255:192]);
        mismatches++;
      end
      if (data[257:256] !== o.kind) begin
        $display("%0t: contact case exp %0d got %0d", $time, o.kind, data[257:256]);
        mismatches++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [263:0] out_tdata;

  overlap_scoreboard sb = new();
  int unsigned cycles = 0;
  int          burst_left = 0;

  sphere_overlap_cap_volume dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // radius_one, radius_two, center_distance from bit 0 up
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // vol one, vol two, surf one, surf two, contact case
  );

  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** sphere_overlap_cap_volume: FAILED **");
      $finish;
    end
  end

  // result side: sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
  end

  // receiver stall pattern: phases of always ready, light, heavy and long stalls
  int unsigned stall_phase = 0;
  always @(negedge clk) begin
    case ((stall_phase / 300) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 2) == 0);
      default: out_tready <= ((stall_phase % 40) >= 25);
    endcase
    stall_phase <= stall_phase + 1;
  end

  // offer one pair; valid stays up within a burst, gaps fall between bursts
  task automatic send_pair(input logic [31:0] r1, input logic [31:0] r2, input logic [31:0] d);
    int gap_len;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {d, r2, r1};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pair(r1, r2, d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
      gap_len    = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6);
      if (gap_len > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap_len - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // random pair shaped towards one contact class
  task automatic send_random_pair();
    longint unsigned r1, r2, sum, gap, d;
    int              mode;
    mode = $urandom_range(0, 9);
    r1 = $urandom;
    r2 = $urandom;
    if (mode >= 6 && mode <= 8) begin
      // realistic particle sizes
      r1 = $urandom_range(1, 32'h00FF_FFFF);
      r2 = $urandom_range(1, 32'h00FF_FFFF);
    end
    sum = r1 + r2;
    gap = (r1 > r2) ? r1 - r2 : r2 - r1;
    case (mode)
      0, 1: d = $urandom;
      2, 3, 6, 7: begin
        // partial overlap
        if (sum > 64'hFFFF_FFFF) sum = 64'h1_0000_0000;
        d = (sum - 1 > gap) ? gap + ({$urandom, $urandom} % (sum - gap)) : gap;
      end
      4, 8: d = (gap > 0) ? {$urandom, $urandom} % gap : 0;  // containment
      default: d = ($urandom_range(0, 1) && sum <= 64'hFFFF_FFFF) ? sum : gap;  // touching
    endcase
    send_pair(r1[31:0], r2[31:0], d[31:0]);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero distance, no contact, partial, containment, saturation
    send_pair(32'd0, 32'd0, 32'd0);
    send_pair(32'h0001_0000, 32'h0001_0000, 32'd0);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_pair(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_pair(32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
    send_pair(32'h0001_0000, 32'h0001_0000, 32'h0001_FFFF);
    send_pair(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_pair(32'h0001_0000, 32'h0003_0000, 32'h0002_0000);
    send_pair(32'h0001_0000, 32'h0003_0000, 32'h0001_FFFF);
    send_pair(32'h0003_0000, 32'h0001_0000, 32'h0000_8000);
    send_pair(32'h0003_0000, 32'h0001_0000, 32'h0002_0000);
    send_pair(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_pair(32'h8000_0000, 32'h0000_0001, 32'h0000_0001);
    send_pair(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    send_pair(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

    repeat (RANDOM_PAIRS) send_random_pair();
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("** sphere_overlap_cap_volume: PASSED **");
    else
      $display("** sphere_overlap_cap_volume: FAILED **");
    $finish;
  end

endmodule
